// ----- rtl/hbp_pkg.sv -----
// Package with the shared types, widths and item codes of the Huffman bit packer.
package hbp_pkg;

    localparam int WORD_BITS     = 32;
    localparam int ALPHABET_SIZE = 256;

    localparam int SYM_W  = 8;
    localparam int LEN_W  = 6;
    localparam int CNT_W  = $clog2(WORD_BITS + 1);
    localparam int ADDR_W = $clog2(ALPHABET_SIZE);
    localparam int KIND_W = 2;

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 40;

    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENCODE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;

    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(WORD_BITS);

    // Item held after the table read, handed on to the packer.
    typedef struct packed {
        logic                 valid;
        logic [KIND_W-1:0]    kind;
        logic [LEN_W-1:0]     len;
        logic [WORD_BITS-1:0] bits;
    } t_lookup;

endpackage

// ----- rtl/huffman_bit_packer.sv -----
// Top level of the Huffman bit packer: stream ports, table read stage and packer.
//
// The block takes one beat per clock cycle while the result output is not
// stalled. The table read stage reads the 256-entry code table into a
// register; the packer then appends the code to the accumulator and loads the
// result register. The rate is set by the single table read port and the
// shift-and-merge in the packer. A beat whose kind is load writes one
// table entry (lengths above 32 are clipped to 32) and emits nothing. An encode
// beat appends the low code_length bits of the stored, already bit-reversed
// code, least significant bit first; each time 32 bits have gathered a full
// word is emitted with a count of 32 and tlast low, and any overflow bits start
// the next word. A flush beat emits the partial word with its bit count and
// tlast high, or nothing when no bits are held. Kind 3 is ignored. Table
// entries hold no defined value until loaded, so every symbol that is encoded
// must have been loaded first. The input stays ready whilst a result waits,
// as long as the table read stage is empty or can still move on.
module huffman_bit_packer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // tdata: symbol [7:0], code_length [13:8], code_bits [45:14], zero [47:46]
    input  logic [hbp_pkg::S_DATA_W-1:0]      i_s_tdata,
    // tuser: kind [1:0]
    input  logic [hbp_pkg::KIND_W-1:0]        i_s_tuser,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // tdata: packed_word [31:0], valid_bits [37:32], zero [39:38]
    output logic [hbp_pkg::M_DATA_W-1:0]      o_m_tdata,
    // tlast: is_final
    output logic                              o_m_tlast
);
    import hbp_pkg::*;

    t_lookup              w_lookup;
    logic                 w_accept;
    logic                 w_go;
    logic                 w_out_valid;
    logic [WORD_BITS-1:0] w_word;
    logic [CNT_W-1:0]     w_count;
    logic                 w_final;

    // The read stage moves on when the result register is empty or being taken.
    assign w_go       = w_lookup.valid && (!w_out_valid || i_m_tready);
    assign o_s_tready = !w_lookup.valid || w_go;
    assign w_accept   = i_s_tvalid && o_s_tready;

    hbp_code_table u_table (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (w_accept),
        .i_go          (w_go),
        .i_kind        (i_s_tuser),
        .i_symbol      (i_s_tdata[SYM_W-1:0]),
        .i_code_length (i_s_tdata[SYM_W+LEN_W-1:SYM_W]),
        .i_code_bits   (i_s_tdata[SYM_W+LEN_W+WORD_BITS-1:SYM_W+LEN_W]),
        .o_lookup      (w_lookup)
    );

    hbp_packer u_packer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (w_go),
        .i_lookup    (w_lookup),
        .i_out_ready (i_m_tready),
        .o_out_valid (w_out_valid),
        .o_word      (w_word),
        .o_count     (w_count),
        .o_final     (w_final)
    );

    assign o_m_tvalid = w_out_valid;
    assign o_m_tdata  = {(M_DATA_W-WORD_BITS-CNT_W)'(0), w_count, w_word};
    assign o_m_tlast  = w_final;

endmodule

// ----- rtl/hbp_code_table.sv -----
// Code table memory and the registered table read stage.
module hbp_code_table (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_accept,
    input  logic                           i_go,
    input  logic [hbp_pkg::KIND_W-1:0]     i_kind,
    input  logic [hbp_pkg::SYM_W-1:0]      i_symbol,
    input  logic [hbp_pkg::LEN_W-1:0]      i_code_length,
    input  logic [hbp_pkg::WORD_BITS-1:0]  i_code_bits,
    output hbp_pkg::t_lookup               o_lookup
);
    import hbp_pkg::*;

    logic [LEN_W+WORD_BITS-1:0] r_mem [ALPHABET_SIZE];
    logic [LEN_W+WORD_BITS-1:0] r_rd;
    logic                       r_valid;
    logic [KIND_W-1:0]          r_kind;
    logic [LEN_W-1:0]           n_len;
    logic [ADDR_W-1:0]          w_addr;
    logic                       w_in_range;

    assign w_addr     = i_symbol[ADDR_W-1:0];
    assign w_in_range = ({1'b0, i_symbol} < (SYM_W+1)'(ALPHABET_SIZE));

    // Lengths above the word size are clipped when the entry is stored.
    always_comb begin
        n_len = (i_code_length > LEN_MAX) ? LEN_MAX : i_code_length;
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && (i_kind == KIND_LOAD) && w_in_range) begin
            r_mem[w_addr] <= {n_len, i_code_bits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_rd <= r_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_kind  <= KIND_LOAD;
        end else if (i_accept) begin
            r_valid <= 1'b1;
            // An encode of a symbol outside the alphabet does nothing.
            r_kind  <= ((i_kind == KIND_ENCODE) && !w_in_range) ? KIND_LOAD : i_kind;
        end else if (i_go) begin
            r_valid <= 1'b0;
        end
    end

    assign o_lookup.valid = r_valid;
    assign o_lookup.kind  = r_kind;
    assign o_lookup.len   = r_rd[LEN_W+WORD_BITS-1:WORD_BITS];
    assign o_lookup.bits  = r_rd[WORD_BITS-1:0];

endmodule

// ----- rtl/hbp_packer.sv -----
// Bit accumulator that appends codes LSB first and registers the emitted words.
module hbp_packer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_go,
    input  hbp_pkg::t_lookup               i_lookup,
    input  logic                           i_out_ready,
    output logic                           o_out_valid,
    output logic [hbp_pkg::WORD_BITS-1:0]  o_word,
    output logic [hbp_pkg::CNT_W-1:0]      o_count,
    output logic                           o_final
);
    import hbp_pkg::*;

    logic [WORD_BITS-1:0]   r_acc;
    logic [CNT_W-1:0]       r_used;
    logic                   r_out_valid;
    logic [WORD_BITS-1:0]   r_word;
    logic [CNT_W-1:0]       r_count;
    logic                   r_final;

    logic [WORD_BITS-1:0]   n_acc;
    logic [CNT_W-1:0]       n_used;
    logic                   n_emit;
    logic [WORD_BITS-1:0]   n_word;
    logic [CNT_W-1:0]       n_count;
    logic                   n_final;

    logic [WORD_BITS-1:0]   w_mask;
    logic [WORD_BITS-1:0]   w_code;
    logic [2*WORD_BITS-1:0] w_shifted;
    logic [WORD_BITS-1:0]   w_merged;
    logic [CNT_W:0]         w_total;

    always_comb begin
        w_mask    = ~({WORD_BITS{1'b1}} << i_lookup.len);
        w_code    = i_lookup.bits & w_mask;
        w_shifted = {{WORD_BITS{1'b0}}, w_code} << r_used;
        w_merged  = r_acc | w_shifted[WORD_BITS-1:0];
        w_total   = {1'b0, r_used} + (CNT_W+1)'(i_lookup.len);

        n_acc   = r_acc;
        n_used  = r_used;
        n_emit  = 1'b0;
        n_word  = w_merged;
        n_count = CNT_W'(WORD_BITS);
        n_final = 1'b0;

        case (i_lookup.kind)
            KIND_ENCODE: begin
                if (w_total >= (CNT_W+1)'(WORD_BITS)) begin
                    n_emit = 1'b1;
                    n_acc  = w_shifted[2*WORD_BITS-1:WORD_BITS];
                    n_used = CNT_W'(w_total - (CNT_W+1)'(WORD_BITS));
                end else begin
                    n_acc  = w_merged;
                    n_used = w_total[CNT_W-1:0];
                end
            end
            KIND_FLUSH: begin
                n_word  = r_acc;
                n_count = r_used;
                n_final = 1'b1;
                if (r_used != '0) begin
                    n_emit = 1'b1;
                    n_acc  = '0;
                    n_used = '0;
                end
            end
            default: begin
                n_acc  = r_acc;
                n_used = r_used;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else if (i_go) begin
            r_acc       <= n_acc;
            r_used      <= n_used;
            r_out_valid <= n_emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go && n_emit) begin
            r_word  <= n_word;
            r_count <= n_count;
            r_final <= n_final;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_word      = r_word;
    assign o_count     = r_count;
    assign o_final     = r_final;

endmodule

// ----- rtl/hbp_checker.sv -----
// Port checker for the Huffman bit packer, bound to the top level.
module hbp_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic                              o_s_tready,
    input  logic [hbp_pkg::S_DATA_W-1:0]      i_s_tdata,
    input  logic [hbp_pkg::KIND_W-1:0]        i_s_tuser,
    input  logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    input  logic [hbp_pkg::M_DATA_W-1:0]      o_m_tdata,
    input  logic                              o_m_tlast
);
    import hbp_pkg::*;

    logic [CNT_W-1:0]     w_count;
    logic [WORD_BITS-1:0] w_word;

    assign w_count = o_m_tdata[WORD_BITS+CNT_W-1:WORD_BITS];
    assign w_word  = o_m_tdata[WORD_BITS-1:0];

    // A stalled result beat holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("stalled result beat changed");

    // Full words always carry the whole word size.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> w_count == CNT_W'(WORD_BITS))
        else $error("full word with a short count");

    // A final word holds between one and the word size of bits.
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> (w_count != '0) && (w_count <= CNT_W'(WORD_BITS)))
        else $error("final word count out of range");

    // Bits above the count of a final word are zero.
    a_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tlast |-> (w_word >> w_count) == '0)
        else $error("final word has bits above its count");

endmodule

bind huffman_bit_packer hbp_checker u_hbp_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
